@@ src/swt_pkg.sv @@
// Shared types, constants and control structs for the sorted vertex weld table.
package swt_pkg;

  // Table geometry
  localparam int MaxVertices = 1024;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int CntW        = AddrW + 1;
  localparam int IdW         = AddrW;
  localparam int CoordW      = 32;
  localparam int TolW        = 20;

  // Configuration port
  localparam int                DataW     = 32;
  localparam int                PaddrW    = 3;
  localparam logic              RegIdxTol = 1'b0;
  localparam logic [TolW-1:0]   TolReset  = TolW'(10);

  typedef struct packed {
    logic signed [CoordW-1:0] x_coord;
    logic signed [CoordW-1:0] y_coord;
    logic signed [CoordW-1:0] z_coord;
  } in_word_t;

  typedef struct packed {
    logic [IdW-1:0]  vertex_id;
    logic            repeated;
    logic            table_full;
    logic [CntW-1:0] entry_count;
  } out_word_t;

  // One table entry: coordinates plus the id handed out on first sight
  typedef struct packed {
    logic [IdW-1:0]           id;
    logic signed [CoordW-1:0] x_coord;
    logic signed [CoordW-1:0] y_coord;
    logic signed [CoordW-1:0] z_coord;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    StIdle,
    StWalkRd,
    StWalkCmp,
    StDecide,
    StShiftRd,
    StShiftWr,
    StInsert,
    StResp
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_vtx;
    logic inc_pos;
    logic rd_pos;
    logic sh_init;
    logic rd_shift;
    logic wr_shift;
    logic wr_insert;
    logic set_repeat;
    logic set_full;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_at_end;
    logic below;
    logic above;
    logic in_band;
    logic full;
    logic shift_done;
  } status_t;

endpackage

@@ src/swt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module swt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/swt_dpath.sv @@
// Datapath: vertex register, walk and shift pointers, entry table, band compare, result words.
module swt_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swt_pkg::cmd_t           cmd_i,
  output swt_pkg::status_t        status_o,
  input  swt_pkg::in_word_t       in_word_i,
  input  logic [swt_pkg::TolW-1:0] tol_i,
  output swt_pkg::out_word_t      out_word_o
);

  typedef enum logic [1:0] {
    BandIn,
    BandBelow,
    BandAbove
  } band_e;

  // Exact signed difference against the +/- tol band
  function automatic band_e band_cmp(input logic signed [swt_pkg::CoordW-1:0] nv,
                                     input logic signed [swt_pkg::CoordW-1:0] sv,
                                     input logic [swt_pkg::TolW-1:0]          tol);
    logic signed [swt_pkg::CoordW:0] diff;
    logic signed [swt_pkg::CoordW:0] lim;
    band_e                           res;
    diff = {nv[swt_pkg::CoordW-1], nv} - {sv[swt_pkg::CoordW-1], sv};
    lim  = {{(swt_pkg::CoordW + 1 - swt_pkg::TolW){1'b0}}, tol};
    if (diff > lim) begin
      res = BandAbove;
    end else if (diff < -lim) begin
      res = BandBelow;
    end else begin
      res = BandIn;
    end
    return res;
  endfunction

  swt_pkg::in_word_t          vtx_q;
  logic [swt_pkg::CntW-1:0]   pos_q, pos_d;
  logic [swt_pkg::CntW-1:0]   sh_q, sh_d;
  logic [swt_pkg::CntW-1:0]   cnt_q, cnt_d;
  swt_pkg::out_word_t         res_q, res_d;
  swt_pkg::out_word_t         out_q;
  logic [swt_pkg::CntW-1:0]   sh_prev;

  logic                       ram_we, ram_re;
  logic [swt_pkg::AddrW-1:0]  ram_waddr, ram_raddr;
  swt_pkg::entry_t            ram_wdata, ram_rdata;
  band_e                      bx, by, bz, bsel;

  assign sh_prev = sh_q - swt_pkg::CntW'(1);

  // Entry table port steering
  always_comb begin
    ram_re    = cmd_i.rd_pos | cmd_i.rd_shift;
    ram_raddr = cmd_i.rd_shift ? sh_prev[swt_pkg::AddrW-1:0] : pos_q[swt_pkg::AddrW-1:0];
    ram_we    = cmd_i.wr_shift | cmd_i.wr_insert;
    ram_waddr = cmd_i.wr_shift ? sh_q[swt_pkg::AddrW-1:0] : pos_q[swt_pkg::AddrW-1:0];
    if (cmd_i.wr_shift) begin
      ram_wdata = ram_rdata;
    end else begin
      ram_wdata.id      = cnt_q[swt_pkg::IdW-1:0];
      ram_wdata.x_coord = vtx_q.x_coord;
      ram_wdata.y_coord = vtx_q.y_coord;
      ram_wdata.z_coord = vtx_q.z_coord;
    end
  end

  swt_ram #(
    .Width(swt_pkg::EntryW),
    .Depth(swt_pkg::MaxVertices)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Lexicographic band compare: first coordinate outside its band decides
  always_comb begin
    bx = band_cmp(vtx_q.x_coord, ram_rdata.x_coord, tol_i);
    by = band_cmp(vtx_q.y_coord, ram_rdata.y_coord, tol_i);
    bz = band_cmp(vtx_q.z_coord, ram_rdata.z_coord, tol_i);
    if (bx != BandIn) begin
      bsel = bx;
    end else if (by != BandIn) begin
      bsel = by;
    end else begin
      bsel = bz;
    end
  end

  always_comb begin
    status_o.pos_at_end = (pos_q == cnt_q);
    status_o.below      = (bsel == BandBelow);
    status_o.above      = (bsel == BandAbove);
    status_o.in_band    = (bsel == BandIn);
    status_o.full       = (cnt_q == swt_pkg::CntW'(swt_pkg::MaxVertices));
    status_o.shift_done = (sh_q == pos_q);
  end

  // Pointers, count and result word
  always_comb begin
    pos_d = pos_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    res_d = res_q;
    if (cmd_i.load_vtx) begin
      pos_d = '0;
    end else if (cmd_i.inc_pos) begin
      pos_d = pos_q + swt_pkg::CntW'(1);
    end
    if (cmd_i.sh_init) begin
      sh_d = cnt_q;
    end else if (cmd_i.wr_shift) begin
      sh_d = sh_prev;
    end
    if (cmd_i.set_repeat) begin
      res_d.vertex_id   = ram_rdata.id;
      res_d.repeated    = 1'b1;
      res_d.table_full  = 1'b0;
      res_d.entry_count = cnt_q;
    end else if (cmd_i.set_full) begin
      res_d.vertex_id   = '0;
      res_d.repeated    = 1'b0;
      res_d.table_full  = 1'b1;
      res_d.entry_count = cnt_q;
    end else if (cmd_i.wr_insert) begin
      cnt_d             = cnt_q + swt_pkg::CntW'(1);
      res_d.vertex_id   = cnt_q[swt_pkg::IdW-1:0];
      res_d.repeated    = 1'b0;
      res_d.table_full  = 1'b0;
      res_d.entry_count = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    sh_q  <= sh_d;
    res_q <= res_d;
    if (cmd_i.load_vtx) begin
      vtx_q <= in_word_i;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_word_o = out_q;

`ifndef SYNTHESIS
  // stored count never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= swt_pkg::CntW'(swt_pkg::MaxVertices))
    else $error("entry count above capacity");
`endif

endmodule

@@ src/swt_ctrl.sv @@
// Controller: walk, shift and insert sequencing plus the output word handshake.
module swt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  swt_pkg::status_t status_i,
  output swt_pkg::cmd_t    cmd_o
);

  swt_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swt_pkg::StIdle: begin
        if (in_valid_i) state_d = swt_pkg::StWalkRd;
      end
      swt_pkg::StWalkRd: begin
        state_d = status_i.pos_at_end ? swt_pkg::StDecide : swt_pkg::StWalkCmp;
      end
      swt_pkg::StWalkCmp: begin
        priority if (status_i.in_band) begin
          state_d = swt_pkg::StResp;
        end else if (status_i.above) begin
          state_d = swt_pkg::StWalkRd;
        end else begin
          state_d = swt_pkg::StDecide;
        end
      end
      swt_pkg::StDecide: begin
        state_d = status_i.full ? swt_pkg::StResp : swt_pkg::StShiftRd;
      end
      swt_pkg::StShiftRd: begin
        state_d = status_i.shift_done ? swt_pkg::StInsert : swt_pkg::StShiftWr;
      end
      swt_pkg::StShiftWr: state_d = swt_pkg::StShiftRd;
      swt_pkg::StInsert:  state_d = swt_pkg::StResp;
      swt_pkg::StResp: begin
        if (out_free) state_d = swt_pkg::StIdle;
      end
      default: state_d = swt_pkg::StIdle;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      swt_pkg::StIdle:    cmd_o.load_vtx = in_valid_i;
      swt_pkg::StWalkRd:  cmd_o.rd_pos   = !status_i.pos_at_end;
      swt_pkg::StWalkCmp: begin
        cmd_o.set_repeat = status_i.in_band;
        cmd_o.inc_pos    = status_i.above;
      end
      swt_pkg::StDecide: begin
        cmd_o.set_full = status_i.full;
        cmd_o.sh_init  = !status_i.full;
      end
      swt_pkg::StShiftRd: cmd_o.rd_shift  = !status_i.shift_done;
      swt_pkg::StShiftWr: cmd_o.wr_shift  = 1'b1;
      swt_pkg::StInsert:  cmd_o.wr_insert = 1'b1;
      swt_pkg::StResp:    cmd_o.load_out  = out_free;
      default:            cmd_o = '0;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != swt_pkg::StIdle);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a result never overwrites a word still stalled at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

  // nothing is inserted into a full table
  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_insert |-> !status_i.full)
    else $error("insert into full table");

  // an accepted word always starts a walk
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == swt_pkg::StWalkRd))
    else $error("accepted word did not start a walk");

  // a result reaches the output in the cycle after it is handed over
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("result lost at output");
`endif

endmodule

@@ src/sorted_vertex_weld_table.sv @@
// Top level: tolerance register on the APB port, controller and datapath.
//
//   channel | direction | payload      | handshake
//   in      | input     | in_word_i    | in_valid_i / in_stall_o
//   out     | output    | out_word_o   | out_valid_o / out_stall_i
//   config  | input     | pwdata/paddr | psel, penable, pwrite, pready
//
// From one accept to the next free input slot an item walks the table: each entry
// compared takes a RAM read then a band compare, and each entry moved to open the
// slot takes a read then a write on the single table RAM; a repeat moves no entries.
// Reset empties the table at once; entries are only read below the count.
// A new word is taken while the previous result waits at a stalled output.
module sorted_vertex_weld_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  swt_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output swt_pkg::out_word_t         out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swt_pkg::PaddrW-1:0] paddr,
  input  logic [swt_pkg::DataW-1:0]  pwdata,
  output logic [swt_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  logic [swt_pkg::TolW-1:0] tol_q, tol_d;
  logic                     reg_sel;
  swt_pkg::cmd_t            cmd;
  swt_pkg::status_t         status;

  // Tolerance register
  assign reg_sel = (paddr[swt_pkg::PaddrW-1] == swt_pkg::RegIdxTol);
  assign pready  = 1'b1;

  always_comb begin
    tol_d = tol_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      tol_d = pwdata[swt_pkg::TolW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= swt_pkg::TolReset;
    end else begin
      tol_q <= tol_d;
    end
  end

  assign prdata = reg_sel ? {{(swt_pkg::DataW - swt_pkg::TolW){1'b0}}, tol_q} : '0;

  swt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swt_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_word_i (in_word_i),
    .tol_i     (tol_q),
    .out_word_o(out_word_o)
  );

endmodule
